// File: hw/rtl/oidh_pkg.sv
// Package for the Opus ID header parser: header offsets, limits, status codes.
// No dependencies; the top level and the checker import it.
package oidh_pkg;

    // Highest channel count accepted by the header check
    localparam logic [7:0] MAX_CHANNELS = 8'd8;

    // Byte offsets inside the identification header
    localparam logic [7:0] OFS_CHANNELS = 8'd9;
    localparam logic [7:0] OFS_SKIP     = 8'd10;
    localparam logic [7:0] OFS_GAIN     = 8'd16;
    localparam logic [7:0] OFS_FAMILY   = 8'd18;
    localparam logic [7:0] OFS_STREAMS  = 8'd19;
    localparam logic [7:0] OFS_COUPLED  = 8'd20;
    localparam logic [7:0] OFS_MAP      = 8'd21;
    localparam logic [7:0] OFS_MAX      = 8'd255;

    // Shortest legal header is 19 bytes: final offset must reach 18
    localparam logic [7:0] HDR_MIN_LAST = 8'd18;
    localparam logic [7:0] DEFAULT_CH   = 8'd2;

    localparam int MAP_DEPTH = 8;

    typedef logic [7:0] map_byte_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_CHANNELS = 3'd2,
        ST_MISSING_MAP  = 3'd3,
        ST_SHORT_MAP    = 3'd4,
        ST_INCONSISTENT = 3'd5
    } hdr_status_t;

endpackage

// File: hw/rtl/oidh_in_if.sv
// Byte stream channel into the Opus ID header parser.
// Depends on nothing; valid/ready handshake with header byte and end flag.
interface oidh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: hw/rtl/oidh_out_if.sv
// Result channel out of the Opus ID header parser.
// Depends on nothing; valid/ready handshake with status and decoded fields.
interface oidh_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         channel_count;
    logic [15:0]        pre_skip;
    logic signed [15:0] output_gain;
    logic [7:0]         mapping_family;
    logic [7:0]         stream_count;
    logic [7:0]         coupled_count;
    logic [63:0]        map_bytes;

    modport source (output valid, output status, output channel_count, output pre_skip,
                    output output_gain, output mapping_family, output stream_count,
                    output coupled_count, output map_bytes, input ready);
    modport sink   (input valid, input status, input channel_count, input pre_skip,
                    input output_gain, input mapping_family, input stream_count,
                    input coupled_count, input map_bytes, output ready);
endinterface

// File: hw/rtl/opus_id_header_parser.sv
// Opus identification header parser: top level.
// Depends on oidh_pkg, oidh_in_if and oidh_out_if.
//
// Takes an Opus ID header one byte per transaction on hdr, the final byte
// flagged by last, and returns one transaction on res for each header: a
// status and the decoded fields. The field registers capture each byte at
// its offset and, on the final byte, the checks run on the just-updated
// fields and load the result register, so a new header byte is accepted
// every cycle while hdr.ready is high, including the cycle right after a
// final byte. res.valid rises in the cycle after the final byte is taken. The
// only stall comes from the result register: hdr.ready drops while a result
// is waiting and res.ready is low. Checks, in priority order: header shorter
// than 19 bytes, channel count zero or above MAX_CHANNELS, family 0 with
// more than two channels, map shorter than the channel count, and stream
// plus coupled count not equal to the channel count. Any error zeroes all
// fields but status. Family 0 reports one stream, coupled = channels > 1 and
// map bytes 0,1. Map entries at or past the channel count read as zero. The
// byte offset saturates at 255 and bytes past offset 28 are ignored; the
// magic and version bytes are not checked. All capture state clears after
// each final byte.
module opus_id_header_parser
    import oidh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    oidh_in_if.sink    hdr,
    oidh_out_if.source res
);

    // Capture state
    logic [7:0]  offset_reg;
    logic [7:0]  chan_reg;
    logic [15:0] skip_reg;
    logic [15:0] gain_reg;
    logic [7:0]  family_reg;
    logic [7:0]  streams_reg;
    logic [7:0]  coupled_reg;
    map_byte_t   map_reg [MAP_DEPTH];

    // Captured values including the byte of the current transaction
    logic [7:0]  chan_next;
    logic [15:0] skip_next;
    logic [15:0] gain_next;
    logic [7:0]  family_next;
    logic [7:0]  streams_next;
    logic [7:0]  coupled_next;
    map_byte_t   map_next [MAP_DEPTH];
    logic [7:0]  offset_next;

    // Result register
    logic               res_valid_reg;
    hdr_status_t        status_reg;
    logic [7:0]         chan_out_reg;
    logic [15:0]        skip_out_reg;
    logic signed [15:0] gain_out_reg;
    logic [7:0]         family_out_reg;
    logic [7:0]         streams_out_reg;
    logic [7:0]         coupled_out_reg;
    logic [63:0]        map_out_reg;

    hdr_status_t status_calc;
    logic [7:0]  streams_calc;
    logic [7:0]  coupled_calc;
    logic [63:0] map_calc;
    logic [63:0] map_custom;
    logic [8:0]  count_sum;
    logic [8:0]  map_end;
    logic        accept;

    assign hdr.ready = !res_valid_reg || res.ready;
    assign accept    = hdr.valid && hdr.ready;

    // Field capture by offset
    always_comb
    begin
        chan_next    = (offset_reg == OFS_CHANNELS) ? hdr.data_byte : chan_reg;
        skip_next    = skip_reg;
        gain_next    = gain_reg;
        if (offset_reg == OFS_SKIP)
            skip_next[7:0] = hdr.data_byte;
        if (offset_reg == OFS_SKIP + 8'd1)
            skip_next[15:8] = hdr.data_byte;
        if (offset_reg == OFS_GAIN)
            gain_next[7:0] = hdr.data_byte;
        if (offset_reg == OFS_GAIN + 8'd1)
            gain_next[15:8] = hdr.data_byte;
        family_next  = (offset_reg == OFS_FAMILY)  ? hdr.data_byte : family_reg;
        streams_next = (offset_reg == OFS_STREAMS) ? hdr.data_byte : streams_reg;
        coupled_next = (offset_reg == OFS_COUPLED) ? hdr.data_byte : coupled_reg;
        for (int i = 0; i < MAP_DEPTH; i++)
        begin
            map_next[i] = (offset_reg == OFS_MAP + 8'(i)) ? hdr.data_byte : map_reg[i];
        end
        offset_next = (offset_reg == OFS_MAX) ? offset_reg : offset_reg + 8'd1;
    end

    // Header checks on the final byte
    always_comb
    begin
        count_sum = {1'b0, streams_next} + {1'b0, coupled_next};
        // Last offset must reach 20 + channels for a complete map
        map_end   = {1'b0, chan_next} + 9'd20;
        map_custom = '0;
        for (int i = 0; i < MAP_DEPTH; i++)
        begin
            if (8'(i) < chan_next)
                map_custom[8*i +: 8] = map_next[i];
        end

        status_calc  = ST_OK;
        streams_calc = '0;
        coupled_calc = '0;
        map_calc     = '0;
        priority if (offset_reg < HDR_MIN_LAST)
            status_calc = ST_TOO_SHORT;
        else if (chan_next == 8'd0 || chan_next > MAX_CHANNELS)
            status_calc = ST_BAD_CHANNELS;
        else if (family_next == 8'd0)
        begin
            if (chan_next > DEFAULT_CH)
                status_calc = ST_MISSING_MAP;
            else
            begin
                streams_calc = 8'd1;
                coupled_calc = (chan_next > 8'd1) ? 8'd1 : 8'd0;
                map_calc     = 64'h0000_0000_0000_0100;
            end
        end
        else if ({1'b0, offset_reg} < map_end)
            status_calc = ST_SHORT_MAP;
        else if (count_sum != {1'b0, chan_next})
            status_calc = ST_INCONSISTENT;
        else
        begin
            streams_calc = streams_next;
            coupled_calc = coupled_next;
            map_calc     = map_custom;
        end
    end

    // Capture state: cleared after every final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            chan_reg    <= '0;
            skip_reg    <= '0;
            gain_reg    <= '0;
            family_reg  <= '0;
            streams_reg <= '0;
            coupled_reg <= '0;
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (hdr.last)
            begin
                offset_reg  <= '0;
                chan_reg    <= '0;
                skip_reg    <= '0;
                gain_reg    <= '0;
                family_reg  <= '0;
                streams_reg <= '0;
                coupled_reg <= '0;
                for (int i = 0; i < MAP_DEPTH; i++)
                begin
                    map_reg[i] <= '0;
                end
            end
            else
            begin
                offset_reg  <= offset_next;
                chan_reg    <= chan_next;
                skip_reg    <= skip_next;
                gain_reg    <= gain_next;
                family_reg  <= family_next;
                streams_reg <= streams_next;
                coupled_reg <= coupled_next;
                for (int i = 0; i < MAP_DEPTH; i++)
                begin
                    map_reg[i] <= map_next[i];
                end
            end
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept && hdr.last)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload; errors report zero fields
    always_ff @(posedge clk)
    begin
        if (accept && hdr.last)
        begin
            status_reg <= status_calc;
            if (status_calc == ST_OK)
            begin
                chan_out_reg    <= chan_next;
                skip_out_reg    <= skip_next;
                gain_out_reg    <= signed'(gain_next);
                family_out_reg  <= family_next;
                streams_out_reg <= streams_calc;
                coupled_out_reg <= coupled_calc;
                map_out_reg     <= map_calc;
            end
            else
            begin
                chan_out_reg    <= '0;
                skip_out_reg    <= '0;
                gain_out_reg    <= '0;
                family_out_reg  <= '0;
                streams_out_reg <= '0;
                coupled_out_reg <= '0;
                map_out_reg     <= '0;
            end
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.status         = status_reg;
    assign res.channel_count  = chan_out_reg;
    assign res.pre_skip       = skip_out_reg;
    assign res.output_gain    = gain_out_reg;
    assign res.mapping_family = family_out_reg;
    assign res.stream_count   = streams_out_reg;
    assign res.coupled_count  = coupled_out_reg;
    assign res.map_bytes      = map_out_reg;

endmodule

// File: hw/rtl/oidh_checker.sv
// Port-level checks for the Opus ID header parser, bound to the top level.
// Depends on oidh_pkg for status codes and limits.
module oidh_checker
    import oidh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [7:0]  channel_count,
    input logic [15:0] pre_skip,
    input logic [7:0]  mapping_family,
    input logic [7:0]  stream_count,
    input logic [7:0]  coupled_count,
    input logic [63:0] map_bytes
);

    // A final byte always produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("final byte did not produce a result");

    // A pending result is not dropped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("pending result dropped or changed");

    // Error results carry zero fields
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> channel_count == 8'd0 && pre_skip == 16'd0
            && stream_count == 8'd0 && coupled_count == 8'd0 && map_bytes == 64'd0)
        else $error("error result with nonzero fields");

    // Good results: channel count in range and counts consistent unless family 0
    a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> channel_count != 8'd0
            && channel_count <= MAX_CHANNELS
            && ({1'b0, stream_count} + {1'b0, coupled_count}
                == {1'b0, channel_count} || mapping_family == 8'd0))
        else $error("good result with inconsistent counts");

    // Default layout reports one stream and the fixed map
    a_ok_default: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && mapping_family == 8'd0
            |-> stream_count == 8'd1 && map_bytes == 64'h0000_0000_0000_0100)
        else $error("default layout result malformed");

endmodule

bind opus_id_header_parser oidh_checker u_oidh_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (hdr.valid),
    .in_ready       (hdr.ready),
    .in_last        (hdr.last),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .status         (res.status),
    .channel_count  (res.channel_count),
    .pre_skip       (res.pre_skip),
    .mapping_family (res.mapping_family),
    .stream_count   (res.stream_count),
    .coupled_count  (res.coupled_count),
    .map_bytes      (res.map_bytes)
);
